### src/wsm_pkg.sv
// ----------------------------------------------------------------------------
// wsm_pkg
// Types, constants and helper functions shared by the wave synth mixer.
// ----------------------------------------------------------------------------
package wsm_pkg;

	localparam int unsigned MAX_CH     = 4;
	localparam int unsigned SR_W       = 17;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned PITCH_W    = 7;
	localparam int unsigned VOL_W      = 4;
	localparam int unsigned AMP_W      = 13;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned DIVD_W     = 29;
	localparam int unsigned DIVS_W     = 16;
	localparam int unsigned DIV_CNT_W  = 5;

	localparam logic [8:0]  AMP_STEP    = 9'd380;
	localparam logic [15:0] NOISE_SEED  = 16'hACE1;
	localparam logic [7:0]  PITCH_BASE  = 8'd60;
	localparam logic [3:0]  OCT_REF     = 4'd10;

	localparam logic signed [16:0] SAT_MAX = 17'sd32767;
	localparam logic signed [16:0] SAT_MIN = -17'sd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMP_RATE    = 3'd0,
		REG_WAVE_CH0    = 3'd1,
		REG_WAVE_CH1    = 3'd2,
		REG_WAVE_CH2    = 3'd3,
		REG_WAVE_CH3    = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		WAVE_SQ50  = 2'd0,
		WAVE_SQ25  = 2'd1,
		WAVE_TRI   = 2'd2,
		WAVE_LFSR  = 2'd3
	} wave_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_PDIV,
		L_UPD,
		L_VAL,
		L_TDIV,
		L_DONE
	} lane_state_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [15:0] value;
	} lane_st_t;

	// Semitone frequencies of the octave starting at C4.
	function automatic logic [8:0] semitone_hz(input logic [3:0] semi);
		logic [8:0] f;
		case (semi)
			4'd0:    f = 9'd262;
			4'd1:    f = 9'd277;
			4'd2:    f = 9'd294;
			4'd3:    f = 9'd311;
			4'd4:    f = 9'd330;
			4'd5:    f = 9'd349;
			4'd6:    f = 9'd370;
			4'd7:    f = 9'd392;
			4'd8:    f = 9'd415;
			4'd9:    f = 9'd440;
			4'd10:   f = 9'd466;
			4'd11:   f = 9'd494;
			default: f = 9'd0;
		endcase
		return f;
	endfunction

	// Tone frequency of a note number. The octave is found by comparing
	// against each multiple of twelve, which are independent compares.
	function automatic logic [DIVS_W-1:0] note_freq(input logic [PITCH_W-1:0] pitch);
		logic [7:0]        p;
		logic [3:0]        oct;
		logic [7:0]        rem;
		logic [DIVS_W-1:0] base;
		p    = {1'b0, pitch} + PITCH_BASE;
		oct  = 4'd0;
		rem  = p;
		for (int o = 1; o < 16; o++) begin
			if (p >= 8'(12 * o)) begin
				oct = 4'(o);
				rem = p - 8'(12 * o);
			end
		end
		base = {7'd0, semitone_hz(rem[3:0])};
		if (oct >= OCT_REF)
			return base << (oct - OCT_REF);
		else
			return base >> (OCT_REF - oct);
	endfunction

endpackage

### src/wsm_if.sv
// ----------------------------------------------------------------------------
// wsm interfaces
// Request channels of the wave synth mixer: note input, sample output and
// register writes.
// ----------------------------------------------------------------------------
interface wsm_in_if;
	logic       valid;
	logic       ready;
	logic [6:0] ch0_pitch;
	logic [3:0] ch0_volume;
	logic       ch0_restart;
	logic [6:0] ch1_pitch;
	logic [3:0] ch1_volume;
	logic       ch1_restart;
	logic [6:0] ch2_pitch;
	logic [3:0] ch2_volume;
	logic       ch2_restart;
	logic [6:0] ch3_pitch;
	logic [3:0] ch3_volume;
	logic       ch3_restart;

	modport source (
		output valid, ch0_pitch, ch0_volume, ch0_restart, ch1_pitch, ch1_volume,
		       ch1_restart, ch2_pitch, ch2_volume, ch2_restart, ch3_pitch,
		       ch3_volume, ch3_restart,
		input  ready
	);
	modport sink (
		input  valid, ch0_pitch, ch0_volume, ch0_restart, ch1_pitch, ch1_volume,
		       ch1_restart, ch2_pitch, ch2_volume, ch2_restart, ch3_pitch,
		       ch3_volume, ch3_restart,
		output ready
	);
endinterface

interface wsm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;

	modport source (output valid, mixed_sample, input ready);
	modport sink (input valid, mixed_sample, output ready);
endinterface

interface wsm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [16:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/wsm_div.sv
// ----------------------------------------------------------------------------
// wsm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsm_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [wsm_pkg::DIVD_W-1:0]       dividend,
	input  logic [wsm_pkg::DIVS_W-1:0]       divisor,
	output logic                             done,
	output logic [wsm_pkg::DIVD_W-1:0]       quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [wsm_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [wsm_pkg::DIVS_W:0]       rem_q;
	logic [wsm_pkg::DIVD_W-1:0]     quo_q;
	logic [wsm_pkg::DIVS_W-1:0]     dvs_q;
	logic [wsm_pkg::DIVS_W:0]       trial;
	logic                           take;

	always_comb begin
		trial = {rem_q[wsm_pkg::DIVS_W-1:0], quo_q[wsm_pkg::DIVD_W-1]};
		take  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= wsm_pkg::DIV_CNT_W'(wsm_pkg::DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wsm_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[wsm_pkg::DIVD_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### src/wsm_lane.sv
// ----------------------------------------------------------------------------
// wsm_lane
// One synth channel: period load, phase step and wave value.
// ----------------------------------------------------------------------------
module wsm_lane #(
	parameter int unsigned LANE = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [wsm_pkg::PITCH_W-1:0]      pitch,
	input  logic [wsm_pkg::VOL_W-1:0]        volume,
	input  logic                             restart,
	input  logic [wsm_pkg::SR_W-1:0]         smp_rate,
	input  wsm_pkg::wave_t                   wave,
	input  logic                             ack,
	output wsm_pkg::lane_st_t                st
);

	wsm_pkg::lane_state_t state_q, state_d;

	logic [wsm_pkg::CNT_W-1:0]   phase_q, period_q;
	logic [15:0]                 noise_q;
	logic                        rst_q;
	logic [wsm_pkg::VOL_W-1:0]   vol_q;
	logic signed [15:0]          val_q;

	logic                        div_start, div_done;
	logic [wsm_pkg::DIVD_W-1:0]  div_dvd, div_quo;
	logic [wsm_pkg::DIVS_W-1:0]  div_dvs;

	logic [wsm_pkg::DIVS_W-1:0]  freq;
	logic [wsm_pkg::AMP_W-1:0]   amp;
	logic [14:0]                 half;
	logic [wsm_pkg::CNT_W-1:0]   tri_t;
	logic [wsm_pkg::CNT_W:0]     phase_inc;
	logic [29:0]                 tri_num;
	logic [15:0]                 noise_nx;
	logic                        sounding;
	logic signed [16:0]          amp_s, tri_val;

	always_comb begin
		freq      = wsm_pkg::note_freq(pitch);
		amp       = {{(wsm_pkg::AMP_W-wsm_pkg::VOL_W){1'b0}}, vol_q}
		            * {4'd0, wsm_pkg::AMP_STEP};
		amp_s     = {4'd0, amp};
		half      = period_q[15:1];
		tri_t     = (phase_q < {1'b0, half}) ? phase_q : (period_q - phase_q);
		tri_num   = {14'd0, tri_t} * {16'd0, amp, 1'b0};
		phase_inc = {1'b0, phase_q} + 1'b1;
		sounding  = (period_q != '0) && (vol_q != '0);
		noise_nx  = {1'b0, noise_q[15] | (noise_q[0] ^ noise_q[1]), noise_q[14:1]};
		tri_val   = $signed({1'b0, div_quo[15:0]}) - amp_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wsm_pkg::L_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = {{(wsm_pkg::DIVD_W-wsm_pkg::SR_W){1'b0}}, smp_rate};
		div_dvs   = freq;
		unique case (state_q)
			wsm_pkg::L_IDLE: begin
				if (start) begin
					if (restart && pitch != '0 && freq != '0) begin
						div_start = 1'b1;
						state_d   = wsm_pkg::L_PDIV;
					end else begin
						state_d = wsm_pkg::L_UPD;
					end
				end
			end
			wsm_pkg::L_PDIV: begin
				if (div_done)
					state_d = wsm_pkg::L_UPD;
			end
			wsm_pkg::L_UPD: state_d = wsm_pkg::L_VAL;
			wsm_pkg::L_VAL: begin
				if (sounding && wave == wsm_pkg::WAVE_TRI && half != '0) begin
					div_start = 1'b1;
					div_dvd   = tri_num[wsm_pkg::DIVD_W-1:0];
					div_dvs   = {1'b0, half};
					state_d   = wsm_pkg::L_TDIV;
				end else begin
					state_d = wsm_pkg::L_DONE;
				end
			end
			wsm_pkg::L_TDIV: begin
				if (div_done)
					state_d = wsm_pkg::L_DONE;
			end
			wsm_pkg::L_DONE: begin
				if (ack)
					state_d = wsm_pkg::L_IDLE;
			end
			default: state_d = wsm_pkg::L_IDLE;
		endcase
	end

	// Phase, period and noise are channel state and survive between samples.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			period_q <= '0;
			noise_q  <= wsm_pkg::NOISE_SEED + 16'(LANE);
		end else begin
			if (state_q == wsm_pkg::L_IDLE && start && restart && state_d == wsm_pkg::L_UPD)
				period_q <= '0;
			if (state_q == wsm_pkg::L_PDIV && div_done)
				period_q <= div_quo[15:0];
			if (state_q == wsm_pkg::L_UPD) begin
				if (rst_q)
					phase_q <= '0;
				else if (period_q != '0)
					phase_q <= (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[15:0];
			end
			if (state_q == wsm_pkg::L_VAL && sounding && wave == wsm_pkg::WAVE_LFSR)
				noise_q <= noise_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wsm_pkg::L_IDLE && start) begin
			rst_q <= restart;
			vol_q <= volume;
		end
		if (state_q == wsm_pkg::L_VAL) begin
			if (!sounding) begin
				val_q <= '0;
			end else begin
				case (wave)
					wsm_pkg::WAVE_SQ50:
						val_q <= ({1'b0, phase_q, 1'b0} < {2'b0, period_q})
						         ? amp_s[15:0] : -amp_s[15:0];
					wsm_pkg::WAVE_SQ25:
						val_q <= ({phase_q, 2'b0} < {2'b0, period_q})
						         ? amp_s[15:0] : -amp_s[15:0];
					wsm_pkg::WAVE_TRI:
						val_q <= '0;
					default:
						val_q <= noise_nx[0] ? amp_s[15:0] : -amp_s[15:0];
				endcase
			end
		end
		if (state_q == wsm_pkg::L_TDIV && div_done)
			val_q <= tri_val[15:0];
	end

	wsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign st.busy  = state_q != wsm_pkg::L_IDLE;
	assign st.done  = state_q == wsm_pkg::L_DONE;
	assign st.value = val_q;

endmodule

### src/wsm_mix.sv
// ----------------------------------------------------------------------------
// wsm_mix
// Saturating mix of the lane values in channel order, with output register.
// ----------------------------------------------------------------------------
module wsm_mix #(
	parameter int unsigned NUM_CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wsm_pkg::lane_st_t  st [NUM_CHANNELS],
	output logic               ack,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_sample
);

	logic               valid_q;
	logic signed [15:0] sample_q;
	logic               all_done;
	logic signed [15:0] acc;
	logic signed [16:0] sum;

	always_comb begin
		all_done = 1'b1;
		acc      = '0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			all_done = all_done & st[c].done;
			sum = {acc[15], acc} + {st[c].value[15], st[c].value};
			if (sum > wsm_pkg::SAT_MAX)
				acc = wsm_pkg::SAT_MAX[15:0];
			else if (sum < wsm_pkg::SAT_MIN)
				acc = wsm_pkg::SAT_MIN[15:0];
			else
				acc = sum[15:0];
		end
		ack = all_done && (!valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ack)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ack)
			sample_q <= acc;
	end

	assign out_valid  = valid_q;
	assign out_sample = sample_q;

endmodule

### src/four_channel_wave_synth_mixer.sv
// ----------------------------------------------------------------------------
// four_channel_wave_synth_mixer
// Four-channel square/triangle/noise synthesizer with saturating mixer.
// ----------------------------------------------------------------------------
// Flow: a taken request steps each lane through update and value states, after a
// period divide when a note restarts, and a triangle divide for a triangle channel.
// A new request waits until every lane and its bit-serial divider are idle again.
// The next request is taken while a finished sample waits in the output reg.
// Reset: arst_n clears phase, period and state; noise seeds, sample rate
// 22050 and waves 0..3 per channel are loaded.
module four_channel_wave_synth_mixer #(
	parameter int unsigned NUM_CHANNELS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	wsm_in_if.sink           in_ch,
	wsm_out_if.source        out_ch,
	wsm_cfg_if.sink          cfg
);

	logic [wsm_pkg::SR_W-1:0]    smp_rate_q;
	wsm_pkg::wave_t              wave_q [wsm_pkg::MAX_CH];
	logic [wsm_pkg::PITCH_W-1:0] pitch_a [wsm_pkg::MAX_CH];
	logic [wsm_pkg::VOL_W-1:0]   vol_a   [wsm_pkg::MAX_CH];
	logic                        rst_a   [wsm_pkg::MAX_CH];
	wsm_pkg::lane_st_t           st      [NUM_CHANNELS];
	logic                        any_busy;
	logic                        accept;
	logic                        ack;

	always_comb begin
		pitch_a[0] = in_ch.ch0_pitch; vol_a[0] = in_ch.ch0_volume; rst_a[0] = in_ch.ch0_restart;
		pitch_a[1] = in_ch.ch1_pitch; vol_a[1] = in_ch.ch1_volume; rst_a[1] = in_ch.ch1_restart;
		pitch_a[2] = in_ch.ch2_pitch; vol_a[2] = in_ch.ch2_volume; rst_a[2] = in_ch.ch2_restart;
		pitch_a[3] = in_ch.ch3_pitch; vol_a[3] = in_ch.ch3_volume; rst_a[3] = in_ch.ch3_restart;
		any_busy = 1'b0;
		for (int c = 0; c < NUM_CHANNELS; c++)
			any_busy = any_busy | st[c].busy;
	end

	assign in_ch.ready = !any_busy;
	assign accept      = in_ch.valid && !any_busy;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_rate_q    <= wsm_pkg::SR_W'(22050);
			wave_q[0]     <= wsm_pkg::WAVE_SQ50;
			wave_q[1]     <= wsm_pkg::WAVE_SQ25;
			wave_q[2]     <= wsm_pkg::WAVE_TRI;
			wave_q[3]     <= wsm_pkg::WAVE_LFSR;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				wsm_pkg::REG_SMP_RATE:    smp_rate_q <= cfg.data;
				wsm_pkg::REG_WAVE_CH0:    wave_q[0] <= wsm_pkg::wave_t'(cfg.data[1:0]);
				wsm_pkg::REG_WAVE_CH1:    wave_q[1] <= wsm_pkg::wave_t'(cfg.data[1:0]);
				wsm_pkg::REG_WAVE_CH2:    wave_q[2] <= wsm_pkg::wave_t'(cfg.data[1:0]);
				wsm_pkg::REG_WAVE_CH3:    wave_q[3] <= wsm_pkg::wave_t'(cfg.data[1:0]);
				default: ;
			endcase
		end
	end

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
		wsm_lane #(.LANE(c)) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.start       (accept),
			.pitch       (pitch_a[c]),
			.volume      (vol_a[c]),
			.restart     (rst_a[c]),
			.smp_rate    (smp_rate_q),
			.wave        (wave_q[c]),
			.ack         (ack),
			.st          (st[c])
		);
	end

	wsm_mix #(.NUM_CHANNELS(NUM_CHANNELS)) u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.st         (st),
		.ack        (ack),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_sample (out_ch.mixed_sample)
	);

endmodule

### src/wsm_checker.sv
// ----------------------------------------------------------------------------
// wsm_checker
// Port-level checks of the wave synth mixer, bound to the top level.
// ----------------------------------------------------------------------------
module wsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_sample
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// A held sample keeps its value until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("output sample changed while stalled");

	// Every taken request makes the lanes busy, so ready drops right after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready stayed high right after a request");

	// A sample never appears in the cycle right after a request was taken.
	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("sample produced too early");

endmodule

bind four_channel_wave_synth_mixer wsm_checker u_wsm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_sample (out_ch.mixed_sample)
);
